// ===== hw/rtl/fpalu_pkg.sv =====
// Shared types, codes and sizing constants for the Q24.8 fixed-point ALU.
// No dependencies; used by fixed_point_alu_q24_8 through scoped names.
`timescale 1ns / 1ps
`default_nettype none

package fpalu_pkg;

    localparam int FRAC_BITS = 8;
    localparam int NUM_W     = 32 + FRAC_BITS;
    localparam int DIV_STEPS = 2;
    localparam int DIV_STG   = (NUM_W + DIV_STEPS - 1) / DIV_STEPS;
    localparam int NUM_STG   = DIV_STG + 3;

    localparam logic [63:0] HALF = (FRAC_BITS == 0) ? 64'd0 : (64'd1 << (FRAC_BITS - 1));
    localparam logic [31:0] MAX32 = 32'h7FFF_FFFF;
    localparam logic [31:0] MIN32 = 32'h8000_0000;

    typedef enum logic [3:0] {
        F_ADD      = 4'd0,
        F_SUB      = 4'd1,
        F_MUL      = 4'd2,
        F_DIV      = 4'd3,
        F_LT       = 4'd4,
        F_GT       = 4'd5,
        F_LE       = 4'd6,
        F_GE       = 4'd7,
        F_EQ       = 4'd8,
        F_NE       = 4'd9,
        F_MIN      = 4'd10,
        F_MAX      = 4'd11,
        F_INC      = 4'd12,
        F_DEC      = 4'd13,
        F_FROM_INT = 4'd14,
        F_TO_INT   = 4'd15
    } t_func;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef struct packed {
        t_func              func;
        logic [31:0]        res;
        logic               truth;
        t_status            st;
        logic [31:0]        den;
        logic               neg;
        logic               a_neg;
        logic               b_zero;
        logic [31:0]        rem;
        logic [NUM_W-1:0]   qn;
    } t_pipe;

    // Applies a sign to a magnitude and saturates to the signed 32-bit range.
    function automatic logic [32:0] signed_sat(input logic [63:0] m, input logic neg);
        logic [32:0] r;
        begin
            if (neg) begin
                if (m > 64'h8000_0000) r = {1'b1, MIN32};
                else r = {1'b0, 32'(~m + 64'd1)};
            end else begin
                if (m > 64'h7FFF_FFFF) r = {1'b1, MAX32};
                else r = {1'b0, m[31:0]};
            end
            return r;
        end
    endfunction

    // Saturates a 33-bit signed sum to 32 bits; bit 32 of the result flags overflow.
    function automatic logic [32:0] sat33(input logic signed [32:0] v);
        logic [32:0] r;
        begin
            if (v[32] != v[31]) r = v[32] ? {1'b1, MIN32} : {1'b1, MAX32};
            else r = {1'b0, v[31:0]};
            return r;
        end
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fixed_point_alu_q24_8.sv =====
// Pipelined signed fixed-point ALU, Q24.8 raw 32-bit values.
// Depends on fpalu_pkg for codes, the stage record and saturation helpers.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
// An operation beat enters on i_in_valid / o_in_ready with i_func, i_operand_a
// and i_operand_b; one result beat leaves on o_out_valid / i_out_ready with
// o_result, o_truth and o_status. Every operation takes the same path, so
// results leave in the order the operations entered.
// The stages are one for the input register and 32x32 product, one for
// rounding, saturation and the simple operations, NUM_STG-3 stages of the
// restoring divider that retire two quotient bits each, and the output
// register where the divide is rounded and selected.
// Throughput is one operation per cycle unless stalled. A stage takes a new
// beat whenever it is empty or its successor moves, so bubbles are squeezed
// out when the receiver stalls, and the pipeline keeps accepting until all
// stages are full. Nothing is lost or repeated while i_out_ready is low.
// Synchronous active-low reset empties the pipeline; no payload is cleared.
module fixed_point_alu_q24_8 (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [3:0]         i_func,
    input  wire logic signed [31:0] i_operand_a,
    input  wire logic signed [31:0] i_operand_b,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic signed [31:0]      o_result,
    output logic                    o_truth,
    output logic [1:0]              o_status
);

    localparam int NS = fpalu_pkg::NUM_STG;
    localparam int NW = fpalu_pkg::NUM_W;

    logic [NS-1:0]          r_v;
    logic [NS:0]            en;

    fpalu_pkg::t_func       r_func0;
    logic signed [31:0]     r_a0;
    logic signed [31:0]     r_b0;
    logic signed [63:0]     r_prod0;

    fpalu_pkg::t_pipe       r_st [1:NS-1];
    fpalu_pkg::t_pipe       n_st [1:NS-1];

    // Ready chain: a stage loads when it is empty or its successor loads.
    always_comb begin
        en[NS] = i_out_ready;
        for (int k = NS - 1; k >= 0; k--) begin
            en[k] = !r_v[k] || en[k+1];
        end
    end

    assign o_in_ready = en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_in_valid;
            for (int k = 1; k < NS; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // Stage 1: simple operations, product rounding and divider setup.
    always_comb begin
        logic signed [32:0] sum;
        logic [63:0]        magp;
        logic [63:0]        mr;
        logic [31:0]        maga;
        logic [31:0]        magb;
        logic [32:0]        sr;
        n_st[1] = '0;
        n_st[1].func = r_func0;
        n_st[1].st = fpalu_pkg::ST_OK;
        maga = r_a0[31] ? 32'(-r_a0) : 32'(r_a0);
        magb = r_b0[31] ? 32'(-r_b0) : 32'(r_b0);
        magp = r_prod0[63] ? 64'(-r_prod0) : 64'(r_prod0);
        mr = (magp + fpalu_pkg::HALF) >> fpalu_pkg::FRAC_BITS;
        sum = '0;
        sr = '0;
        case (r_func0)
            fpalu_pkg::F_ADD, fpalu_pkg::F_SUB, fpalu_pkg::F_INC, fpalu_pkg::F_DEC: begin
                case (r_func0)
                    fpalu_pkg::F_ADD: sum = 33'(r_a0) + 33'(r_b0);
                    fpalu_pkg::F_SUB: sum = 33'(r_a0) - 33'(r_b0);
                    fpalu_pkg::F_INC: sum = 33'(r_a0) + 33'sd1;
                    default:          sum = 33'(r_a0) - 33'sd1;
                endcase
                sr = fpalu_pkg::sat33(sum);
            end
            fpalu_pkg::F_MUL:      sr = fpalu_pkg::signed_sat(mr, r_prod0[63]);
            fpalu_pkg::F_FROM_INT: sr = fpalu_pkg::signed_sat(64'(maga) << fpalu_pkg::FRAC_BITS,
                                                              r_a0[31]);
            fpalu_pkg::F_TO_INT:   sr = {1'b0, 32'(r_a0 >>> fpalu_pkg::FRAC_BITS)};
            fpalu_pkg::F_MIN:      sr = {1'b0, (r_a0 < r_b0) ? r_a0 : r_b0};
            fpalu_pkg::F_MAX:      sr = {1'b0, (r_a0 > r_b0) ? r_a0 : r_b0};
            fpalu_pkg::F_LT:       n_st[1].truth = (r_a0 < r_b0);
            fpalu_pkg::F_GT:       n_st[1].truth = (r_a0 > r_b0);
            fpalu_pkg::F_LE:       n_st[1].truth = (r_a0 <= r_b0);
            fpalu_pkg::F_GE:       n_st[1].truth = (r_a0 >= r_b0);
            fpalu_pkg::F_EQ:       n_st[1].truth = (r_a0 == r_b0);
            fpalu_pkg::F_NE:       n_st[1].truth = (r_a0 != r_b0);
            default:               sr = '0;
        endcase
        n_st[1].res = sr[31:0];
        if (sr[32]) n_st[1].st = fpalu_pkg::ST_OVF;
        n_st[1].den = magb;
        n_st[1].neg = r_a0[31] ^ r_b0[31];
        n_st[1].a_neg = r_a0[31];
        n_st[1].b_zero = (r_b0 == 32'sd0);
        n_st[1].rem = '0;
        n_st[1].qn = NW'(maga) << fpalu_pkg::FRAC_BITS;
    end

    // Divider stages: each retires DIV_STEPS quotient bits of |a| << FRAC_BITS.
    for (genvar gs = 2; gs < NS - 1; gs++) begin : g_div
        always_comb begin
            logic [32:0] rem2;
            logic        qbit;
            n_st[gs] = r_st[gs-1];
            for (int j = 0; j < fpalu_pkg::DIV_STEPS; j++) begin
                rem2 = {n_st[gs].rem, n_st[gs].qn[NW-1]};
                qbit = (rem2 >= {1'b0, n_st[gs].den});
                if ((gs - 2) * fpalu_pkg::DIV_STEPS + j < NW) begin
                    n_st[gs].rem = qbit ? 32'(rem2 - {1'b0, n_st[gs].den}) : rem2[31:0];
                    n_st[gs].qn = {n_st[gs].qn[NW-2:0], qbit};
                end
            end
        end
    end

    // Output stage: round the quotient half away from zero and select.
    always_comb begin
        logic        rnd;
        logic [32:0] dr;
        n_st[NS-1] = r_st[NS-2];
        rnd = ({r_st[NS-2].rem, 1'b0} >= {1'b0, r_st[NS-2].den});
        dr = fpalu_pkg::signed_sat(64'(r_st[NS-2].qn) + 64'(rnd), r_st[NS-2].neg);
        if (r_st[NS-2].func == fpalu_pkg::F_DIV) begin
            if (r_st[NS-2].b_zero) begin
                n_st[NS-1].res = r_st[NS-2].a_neg ? fpalu_pkg::MIN32 : fpalu_pkg::MAX32;
                n_st[NS-1].st = fpalu_pkg::ST_DIV0;
            end else begin
                n_st[NS-1].res = dr[31:0];
                n_st[NS-1].st = dr[32] ? fpalu_pkg::ST_OVF : fpalu_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_func0 <= fpalu_pkg::t_func'(i_func);
            r_a0 <= i_operand_a;
            r_b0 <= i_operand_b;
            r_prod0 <= i_operand_a * i_operand_b;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) r_st[k] <= n_st[k];
        end
    end

    assign o_out_valid = r_v[NS-1];
    assign o_result = r_st[NS-1].res;
    assign o_truth = r_st[NS-1].truth;
    assign o_status = r_st[NS-1].st;

`ifndef ASSERT_OFF
    a_div0_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fpalu_pkg::ST_DIV0) |->
        (o_result == fpalu_pkg::MAX32 || o_result == fpalu_pkg::MIN32))
        else $error("divide by zero result is not saturated");
    a_ovf_sat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == fpalu_pkg::ST_OVF) |->
        (o_result == fpalu_pkg::MAX32 || o_result == fpalu_pkg::MIN32))
        else $error("overflow result is not at a range bound");
    a_truth_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_truth) |-> (o_result == 32'sd0 && o_status == fpalu_pkg::ST_OK))
        else $error("comparison beat carries a result or status");
`endif

endmodule

`default_nettype wire
